// ----- src/ffa_pkg.sv -----
`default_nettype none

package ffa_pkg;

   // Default sizing of the arena. ALIGN_BYTES is a power of two and
   // POOL_BYTES a multiple of it.
   localparam int POOL_BYTES_DEF   = 65536;
   localparam int ALIGN_BYTES_DEF  = 16;
   localparam int HEADER_BYTES_DEF = 16;

   // Depth of the queue between the front and the back end
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_REALLOC = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Classified request handed from the front to the back end
   typedef struct packed {
      op_type      op;
      logic        has;
      logic        oversize;
      logic        zero;
      logic        in_pool;
      logic [15:0] addr;
   } cmd_type;

endpackage

`default_nettype wire

// ----- src/ffa_chan_if.sv -----
`default_nettype none

// Request channel
interface ffa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] item_count;
   logic [31:0] item_bytes;
   logic        has_address;
   logic [15:0] payload_offset;

   modport source (output valid, op, item_count, item_bytes, has_address, payload_offset,
                   input ready);
   modport sink   (input valid, op, item_count, item_bytes, has_address, payload_offset,
                   output ready);
endinterface

// Response channel
interface ffa_rsp_if;
   logic        valid;
   logic        ready;
   logic        granted;
   logic [15:0] result_offset;

   modport source (output valid, granted, result_offset, input ready);
   modport sink   (input valid, granted, result_offset, output ready);
endinterface

`default_nettype wire

// ----- src/ffa_front.sv -----
`default_nettype none

module ffa_front import ffa_pkg::*; #(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   localparam int SCW = $clog2(POOL_BYTES / ALIGN_BYTES + 1)
) (
   input  logic           clock,
   input  logic           reset,
   ffa_req_if.sink        req_bus,
   output logic           push_valid,
   input  logic           push_ready,
   output cmd_type        push_cmd,
   output logic [SCW-1:0] push_need
);

   localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
   localparam int HDR_SPAN    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int PW          = $clog2(POOL_BYTES + ALIGN_BYTES);

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff, s1_op_in;
   logic [31:0] s1_count_ff, s1_count_in;
   logic [31:0] s1_bytes_ff, s1_bytes_in;
   logic        s1_has_ff, s1_has_in;
   logic [15:0] s1_addr_ff, s1_addr_in;

   logic        s2_valid_ff, s2_valid_in;
   logic [1:0]  s2_op_ff, s2_op_in;
   logic        s2_has_ff, s2_has_in;
   logic [15:0] s2_addr_ff, s2_addr_in;
   logic [63:0] prod_ff, prod_in;

   logic           s2_take;
   logic           s1_load;
   logic [PW-1:0]  rounded;
   logic [SCW-1:0] need_cells;
   logic           zero;

   assign s2_take       = !s2_valid_ff || push_ready;
   assign req_bus.ready = !s1_valid_ff || s2_take;
   assign s1_load       = req_bus.valid && req_bus.ready;

   // Stage one holds the raw beat, stage two the product of count and size
   always_comb begin
      s1_valid_in = s1_load ? 1'b1 : (s2_take ? 1'b0 : s1_valid_ff);
      s1_op_in    = s1_load ? req_bus.op : s1_op_ff;
      s1_count_in = s1_load ? req_bus.item_count : s1_count_ff;
      s1_bytes_in = s1_load ? req_bus.item_bytes : s1_bytes_ff;
      s1_has_in   = s1_load ? req_bus.has_address : s1_has_ff;
      s1_addr_in  = s1_load ? req_bus.payload_offset : s1_addr_ff;

      s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;
      s2_op_in    = s2_op_ff;
      s2_has_in   = s2_has_ff;
      s2_addr_in  = s2_addr_ff;
      prod_in     = prod_ff;
      if (s2_take && s1_valid_ff) begin
         s2_op_in   = s1_op_ff;
         s2_has_in  = s1_has_ff;
         s2_addr_in = s1_addr_ff;
         prod_in    = 64'(s1_count_ff) * 64'(s1_bytes_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_op_ff    <= s1_op_in;
      s1_count_ff <= s1_count_in;
      s1_bytes_ff <= s1_bytes_in;
      s1_has_ff   <= s1_has_in;
      s1_addr_ff  <= s1_addr_in;
      s2_op_ff    <= s2_op_in;
      s2_has_ff   <= s2_has_in;
      s2_addr_ff  <= s2_addr_in;
      prod_ff     <= prod_in;
   end

   // Classify: size check, round up to cells, address range
   assign rounded    = PW'(prod_ff[PW-1:0]) + PW'(ALIGN_BYTES - 1);
   assign need_cells = SCW'(rounded >> ALIGN_SHIFT);
   assign zero       = (prod_ff == 64'd0);

   always_comb begin
      push_cmd.op       = op_type'(s2_op_ff);
      push_cmd.has      = s2_has_ff;
      push_cmd.oversize = (prod_ff > 64'(POOL_BYTES));
      push_cmd.zero     = zero;
      push_cmd.in_pool  = (32'(s2_addr_ff) >= 32'(HDR_SPAN)) &&
                          (32'(s2_addr_ff) < 32'(POOL_BYTES));
      push_cmd.addr     = s2_addr_ff;
      push_need         = zero ? SCW'(1) : need_cells;
   end

   assign push_valid = s2_valid_ff;

endmodule

`default_nettype wire

// ----- src/ffa_queue.sv -----
`default_nettype none

module ffa_queue import ffa_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNTW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);
      end
      count_in = count_ff + CNTW'(do_push) - CNTW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/ffa_back.sv -----
`default_nettype none

module ffa_back import ffa_pkg::*; #(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   localparam int SCW = $clog2(POOL_BYTES / ALIGN_BYTES + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  cmd_type        pop_cmd,
   input  logic [SCW-1:0] pop_need,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_granted,
   output logic [15:0]    rsp_result_offset
);

   localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
   localparam int HDR_SPAN    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int HDR_CELLS   = HDR_SPAN / ALIGN_BYTES;
   localparam int CELL_COUNT  = POOL_BYTES / ALIGN_BYTES;
   localparam int CIW         = $clog2(CELL_COUNT);
   localparam int NW          = SCW + 2;
   localparam int WALK_MAX    = CELL_COUNT / (HDR_CELLS + 1);
   localparam int GW          = $clog2(WALK_MAX + 1);

   typedef struct packed {
      logic           free;
      logic [SCW-1:0] size;
   } hdr_type;

   typedef enum logic [12:0] {
      S_INIT     = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_FIT_RD   = 13'b0000000000100,
      S_FIT_CHK  = 13'b0000000001000,
      S_FIT_WR   = 13'b0000000010000,
      S_FREE_RD  = 13'b0000000100000,
      S_FREE_WR  = 13'b0000001000000,
      S_MG_RD    = 13'b0000010000000,
      S_MG_HEAD  = 13'b0000100000000,
      S_MG_NXT   = 13'b0001000000000,
      S_RA_RD    = 13'b0010000000000,
      S_RA_CHK   = 13'b0100000000000,
      S_SPARE    = 13'b1000000000000
   } state_type;

   // Header store: one entry per cell, payload size counted in cells
   hdr_type mem [CELL_COUNT];
   hdr_type rd_data_ff;

   logic           mem_rd_en;
   logic [CIW-1:0] mem_rd_addr;
   logic           mem_wr_en;
   logic [CIW-1:0] mem_wr_addr;
   hdr_type        mem_wr_data;

   state_type      state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [SCW-1:0] need_ff, need_in;
   logic [NW-1:0]  cur_ff, cur_in;
   logic [GW-1:0]  guard_ff, guard_in;
   logic [SCW-1:0] head_ff, head_in;
   logic [CIW-1:0] found_ff, found_in;
   logic [SCW-1:0] fit_size_ff, fit_size_in;
   logic           move_ff, move_in;
   logic           grant_ff, grant_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_grant_ff, rsp_grant_in;
   logic [15:0]    rsp_off_ff, rsp_off_in;

   logic           finish;
   logic           fin_grant;
   logic [15:0]    fin_off;
   logic [31:0]    addr_diff;
   logic [CIW-1:0] addr_cell;
   logic [31:0]    found_bytes;
   logic [NW-1:0]  after_rd;
   logic [NW-1:0]  after_head;
   logic [NW-1:0]  rest_cell;
   logic [SCW-1:0] grown;
   logic [NW-1:0]  after_grown;
   logic           walk_end;

   assign addr_diff   = 32'(cmd_ff.addr) - 32'(HDR_SPAN);
   assign addr_cell   = CIW'(addr_diff >> ALIGN_SHIFT);
   assign found_bytes = (32'(found_ff) + 32'(HDR_CELLS)) << ALIGN_SHIFT;
   assign after_rd    = cur_ff + NW'(HDR_CELLS) + NW'(rd_data_ff.size);
   assign after_head  = cur_ff + NW'(HDR_CELLS) + NW'(head_ff);
   assign rest_cell   = cur_ff + NW'(HDR_CELLS) + NW'(need_ff);
   assign grown       = head_ff + SCW'(HDR_CELLS) + rd_data_ff.size;
   assign after_grown = cur_ff + NW'(HDR_CELLS) + NW'(grown);
   assign walk_end    = (guard_ff == GW'(WALK_MAX)) || (cur_ff >= NW'(CELL_COUNT));

   assign pop_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // Sequencer: walk the block chain one header read at a time
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      need_in     = need_ff;
      cur_in      = cur_ff;
      guard_in    = guard_ff;
      head_in     = head_ff;
      found_in    = found_ff;
      fit_size_in = fit_size_ff;
      move_in     = move_ff;
      grant_in    = grant_ff;
      finish      = 1'b0;
      fin_grant   = 1'b0;
      fin_off     = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = CIW'(cur_ff);
      mem_wr_en   = 1'b0;
      mem_wr_addr = CIW'(cur_ff);
      mem_wr_data = '0;

      case (state_ff)
         S_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = '{free: 1'b1, size: SCW'(CELL_COUNT - HDR_CELLS)};
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            if (pop_valid && pop_ready) begin
               cmd_in   = pop_cmd;
               need_in  = pop_need;
               cur_in   = '0;
               guard_in = '0;
               grant_in = 1'b0;
               move_in  = 1'b0;
               case (pop_cmd.op)
                  OP_ALLOC: begin
                     if (pop_cmd.oversize) begin
                        finish = 1'b1;
                     end else begin
                        state_in = S_FIT_RD;
                     end
                  end
                  OP_FREE: begin
                     if (pop_cmd.has && pop_cmd.in_pool) begin
                        state_in = S_FREE_RD;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  OP_REALLOC: begin
                     if (!pop_cmd.has) begin
                        if (pop_cmd.oversize) begin
                           finish = 1'b1;
                        end else begin
                           state_in = S_FIT_RD;
                        end
                     end else if (!pop_cmd.in_pool || pop_cmd.oversize) begin
                        finish = 1'b1;
                     end else if (pop_cmd.zero) begin
                        state_in = S_FREE_RD;
                     end else begin
                        state_in = S_RA_RD;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_FIT_RD: begin
            if (walk_end) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_FIT_CHK;
            end
         end
         S_FIT_CHK: begin
            if (rd_data_ff.free && (rd_data_ff.size >= need_ff)) begin
               found_in    = CIW'(cur_ff);
               grant_in    = 1'b1;
               fit_size_in = rd_data_ff.size;
               // Split off the tail when it holds a header and one cell
               if ((rd_data_ff.size - need_ff) >= SCW'(HDR_CELLS + 1)) begin
                  fit_size_in = need_ff;
                  if (rest_cell < NW'(CELL_COUNT)) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = CIW'(rest_cell);
                     mem_wr_data = '{free: 1'b1,
                                     size: rd_data_ff.size - need_ff - SCW'(HDR_CELLS)};
                  end
               end
               state_in = S_FIT_WR;
            end else begin
               cur_in   = after_rd;
               guard_in = guard_ff + GW'(1);
               state_in = S_FIT_RD;
            end
         end
         S_FIT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = found_ff;
            mem_wr_data = '{free: 1'b0, size: fit_size_ff};
            if (move_ff) begin
               state_in = S_FREE_RD;
            end else begin
               finish    = 1'b1;
               fin_grant = 1'b1;
               fin_off   = found_bytes[15:0];
               state_in  = S_IDLE;
            end
         end
         S_FREE_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = addr_cell;
            state_in    = S_FREE_WR;
         end
         S_FREE_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_cell;
            mem_wr_data = '{free: 1'b1, size: rd_data_ff.size};
            cur_in      = '0;
            guard_in    = '0;
            state_in    = S_MG_RD;
         end
         S_MG_RD: begin
            if (walk_end) begin
               finish    = 1'b1;
               fin_grant = grant_ff;
               fin_off   = grant_ff ? found_bytes[15:0] : 16'd0;
               state_in  = S_IDLE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_MG_HEAD;
            end
         end
         S_MG_HEAD: begin
            head_in = rd_data_ff.size;
            if (rd_data_ff.free && (after_rd < NW'(CELL_COUNT))) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = CIW'(after_rd);
               state_in    = S_MG_NXT;
            end else begin
               cur_in   = after_rd;
               guard_in = guard_ff + GW'(1);
               state_in = S_MG_RD;
            end
         end
         S_MG_NXT: begin
            if (rd_data_ff.free) begin
               // Absorb the free neighbor and look at the one after it
               head_in     = grown;
               mem_wr_en   = 1'b1;
               mem_wr_data = '{free: 1'b1, size: grown};
               if (after_grown < NW'(CELL_COUNT)) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = CIW'(after_grown);
               end else begin
                  cur_in   = after_grown;
                  guard_in = guard_ff + GW'(1);
                  state_in = S_MG_RD;
               end
            end else begin
               cur_in   = after_head;
               guard_in = guard_ff + GW'(1);
               state_in = S_MG_RD;
            end
         end
         S_RA_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = addr_cell;
            state_in    = S_RA_CHK;
         end
         S_RA_CHK: begin
            if (rd_data_ff.size >= need_ff) begin
               finish    = 1'b1;
               fin_grant = 1'b1;
               fin_off   = cmd_ff.addr;
               state_in  = S_IDLE;
            end else begin
               move_in  = 1'b1;
               cur_in   = '0;
               guard_in = '0;
               state_in = S_FIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Load the response register when a request completes, drop it on a beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_off_in   = rsp_off_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_grant_in = fin_grant;
         rsp_off_in   = fin_off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         grant_ff     <= 1'b0;
         move_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         grant_ff     <= grant_in;
         move_ff      <= move_in;
      end
      cmd_ff       <= cmd_in;
      need_ff      <= need_in;
      cur_ff       <= cur_in;
      guard_ff     <= guard_in;
      head_ff      <= head_in;
      found_ff     <= found_in;
      fit_size_ff  <= fit_size_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_off_ff   <= rsp_off_in;
   end

   // Header memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_grant_ff;
   assign rsp_result_offset = rsp_off_ff;

endmodule

`default_nettype wire

// ----- src/first_fit_arena_allocator.sv -----
// First-fit arena allocator with in-band block headers.
// Requests arrive on req_bus (valid/ready): op selects allocate, free or
// reallocate; item_count * item_bytes is the size, payload_offset with
// has_address names an existing payload. Every request beat yields exactly
// one response beat on rsp_bus: granted and the payload byte offset (0 when
// not granted), in request order.
// The front end's stage one registers the beat and stage two the 32x32
// product, which is classified and placed in a two-entry queue from which
// the back end pops it. The back end walks the block chain in the header
// memory: an allocate reads one header per block until it finds a free
// block that fits, then writes the split-off tail, if any, and that
// block's header; a free rewrites the block's header and then runs a merge
// pass over the whole arena. The back end has a single header read port
// and processes requests one at a time. Reset clears the valid flags,
// queue pointers and sequencer state; the init state after reset writes
// the one free whole-pool header, and requests are queued meanwhile.
// A stalled receiver holds the response register; the front end keeps
// accepting until the queue and its two stages are full.
`default_nettype none

module first_fit_arena_allocator import ffa_pkg::*; #(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ffa_req_if.sink   req_bus,
   ffa_rsp_if.source rsp_bus
);

   localparam int SCW    = $clog2(POOL_BYTES / ALIGN_BYTES + 1);
   localparam int QW     = $bits(cmd_type) + SCW;

   logic           push_valid, push_ready;
   cmd_type        push_cmd;
   logic [SCW-1:0] push_need;
   logic           pop_valid, pop_ready;
   logic [QW-1:0]  pop_data;
   cmd_type        pop_cmd;
   logic [SCW-1:0] pop_need;

   ffa_front #(
      .POOL_BYTES   (POOL_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .push_need  (push_need)
   );

   ffa_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_cmd, push_need}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_cmd  = cmd_type'(pop_data[QW-1:SCW]);
   assign pop_need = pop_data[SCW-1:0];

   ffa_back #(
      .POOL_BYTES   (POOL_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_cmd           (pop_cmd),
      .pop_need          (pop_need),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_granted       (rsp_bus.granted),
      .rsp_result_offset (rsp_bus.result_offset)
   );

endmodule

`default_nettype wire

// ----- src/ffa_checker.sv -----
`default_nettype none

module ffa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_granted,
   input wire logic [15:0] rsp_result_offset
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_granted) && $stable(rsp_result_offset))
      else $error("response payload changed while stalled");

   // A refused request carries no offset
   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_result_offset == 16'd0)
      else $error("offset given without grant");

   // No response right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind first_fit_arena_allocator ffa_checker u_ffa_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_granted       (rsp_bus.granted),
   .rsp_result_offset (rsp_bus.result_offset)
);

`default_nettype wire

// ----- bench/tb_first_fit_arena_allocator.sv -----
`default_nettype none

module tb_first_fit_arena_allocator;
   import ffa_pkg::*;

   localparam int POOL      = POOL_BYTES_DEF;
   localparam int ALIGN     = ALIGN_BYTES_DEF;
   localparam int HSPAN     = ((HEADER_BYTES_DEF + ALIGN - 1) / ALIGN) * ALIGN;
   localparam int CELLS     = (POOL + ALIGN - 1) / ALIGN;
   localparam int WALK_MAX  = POOL / (HSPAN + ALIGN);
   localparam int N_RANDOM  = 1420;
   localparam int IDLE_MAX  = 200000;

   typedef struct {
      op_type      op;
      logic [31:0] count;
      logic [31:0] each;
      logic        has;
      logic [15:0] addr;
   } request_t;

   typedef struct {
      logic        granted;
      logic [15:0] offset;
   } answer_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffa_req_if req_bus ();
   ffa_rsp_if rsp_bus ();

   first_fit_arena_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow arena: payload size and free mark per cell, plus a written mark
   bit [31:0] cell_size [CELLS];
   bit        cell_free [CELLS];
   bit        cell_seen [CELLS];

   request_t    pending_q[$];
   answer_t     answer_q[$];
   logic [15:0] granted_q[$];
   int          failures = 0;
   int          idle_cycles = 0;

   function automatic longint unsigned next_block(longint unsigned off);
      return off + HSPAN + cell_size[off / ALIGN];
   endfunction

   function automatic void put_header(longint unsigned idx, bit [31:0] sz, bit fr);
      cell_size[idx] = sz;
      cell_free[idx] = fr;
      cell_seen[idx] = 1'b1;
   endfunction

   // Merge every run of adjacent free blocks, walking from the arena start
   function automatic void merge_free_runs();
      longint unsigned off, nxt, idx;
      off = 0;
      for (int g = 0; g < WALK_MAX; g++) begin
         if (off >= POOL) break;
         idx = off / ALIGN;
         if (cell_free[idx]) begin
            nxt = next_block(off);
            while (nxt < POOL && cell_free[nxt / ALIGN]) begin
               cell_size[idx] = cell_size[idx] + HSPAN + cell_size[nxt / ALIGN];
               nxt = next_block(off);
            end
         end
         off = next_block(off);
      end
   endfunction

   function automatic bit size_ok(logic [31:0] cnt, logic [31:0] each,
                                  output longint unsigned need);
      longint unsigned prod;
      prod = longint'(cnt) * longint'(each);
      need = ((prod + ALIGN - 1) / ALIGN) * ALIGN;
      return prod <= POOL;
   endfunction

   // First fit over the block chain, split when the rest holds a header and a cell
   function automatic bit first_fit(logic [31:0] cnt, logic [31:0] each,
                                    output longint unsigned payload);
      longint unsigned need, off, idx, have, rest;
      payload = 0;
      if (!size_ok(cnt, each, need)) return 1'b0;
      if (need == 0) need = ALIGN;
      off = 0;
      for (int g = 0; g < WALK_MAX; g++) begin
         if (off >= POOL) break;
         idx = off / ALIGN;
         if (cell_free[idx] && cell_size[idx] >= need) begin
            have = cell_size[idx];
            if (have - need >= HSPAN + ALIGN) begin
               rest = off + HSPAN + need;
               if (rest < POOL) put_header(rest / ALIGN, have - need - HSPAN, 1'b1);
               cell_size[idx] = need;
            end
            cell_free[idx] = 1'b0;
            payload = off + HSPAN;
            return 1'b1;
         end
         off = next_block(off);
      end
      return 1'b0;
   endfunction

   function automatic bit addr_in_pool(logic [15:0] a);
      return a >= HSPAN && a < POOL;
   endfunction

   function automatic void release_block(logic [15:0] a);
      if (!addr_in_pool(a)) return;
      cell_free[(a - HSPAN) / ALIGN] = 1'b1;
      merge_free_runs();
   endfunction

   function automatic answer_t serve_request(request_t r);
      answer_t         ans;
      longint unsigned res, need;
      bit              ok;
      res = 0;
      ok  = 1'b0;
      case (r.op)
         OP_ALLOC: ok = first_fit(r.count, r.each, res);
         OP_FREE: begin
            if (r.has) release_block(r.addr);
         end
         OP_REALLOC: begin
            if (!r.has) begin
               ok = first_fit(r.count, r.each, res);
            end else if (addr_in_pool(r.addr) && size_ok(r.count, r.each, need)) begin
               if (need == 0) begin
                  release_block(r.addr);
               end else if (cell_size[(r.addr - HSPAN) / ALIGN] >= need) begin
                  ok  = 1'b1;
                  res = r.addr;
               end else if (first_fit(r.count, r.each, res)) begin
                  release_block(r.addr);
                  ok = 1'b1;
               end
            end
         end
         default: ;
      endcase
      ans.granted = ok;
      ans.offset  = ok ? res[15:0] : 16'd0;
      return ans;
   endfunction

   function automatic void push_request(op_type op, logic [31:0] cnt, logic [31:0] each,
                                        logic has, logic [15:0] addr);
      request_t r;
      r.op = op; r.count = cnt; r.each = each; r.has = has; r.addr = addr;
      pending_q.push_back(r);
   endfunction

   // Pick an address: granted offset, near a written header, or below the header span
   function automatic logic [15:0] pick_address();
      int          k, idx;
      logic [15:0] a;
      k = $urandom_range(99);
      if (k < 75 && granted_q.size() > 0) begin
         idx = $urandom_range(granted_q.size() - 1);
         a = granted_q[idx];
         granted_q.delete(idx);
         if ($urandom_range(7) == 0) a[3:0] = $urandom_range(15);
      end else if (k < 88) begin
         do idx = $urandom_range(CELLS - 2); while (!cell_seen[idx]);
         a = idx * ALIGN + HSPAN + $urandom_range(ALIGN - 1);
      end else begin
         a = $urandom_range(HSPAN - 1);
      end
      return a;
   endfunction

   function automatic void pick_size(output logic [31:0] cnt, output logic [31:0] each);
      int k;
      k = $urandom_range(99);
      if (k < 65) begin
         cnt = $urandom_range(1, 48); each = $urandom_range(1, 64);
      end else if (k < 75) begin
         cnt = $urandom_range(1) ? 32'd0 : $urandom; each = $urandom_range(1) ? $urandom : 32'd0;
      end else if (k < 87) begin
         cnt = $urandom; each = $urandom;
      end else begin
         cnt = $urandom_range(1, 6000); each = 1;
      end
   endfunction

   // Drive requests in bursts with random gaps between them
   int burst_left = 0;
   int gap_left   = 0;
   int rdy_cycle  = 0;
   int rdy_mode   = 0;
   logic req_taken = 1'b0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = OP_NONE;
      req_bus.item_count = '0;
      req_bus.item_bytes = '0;
      req_bus.has_address = 1'b0;
      req_bus.payload_offset = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(negedge clock) begin
      request_t r;
      if (!reset && !(req_bus.valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            r = pending_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.op <= r.op;
            req_bus.item_count <= r.count;
            req_bus.item_bytes <= r.each;
            req_bus.has_address <= r.has;
            req_bus.payload_offset <= r.addr;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls on its own pattern: free running, random, mostly stalled
   always @(negedge clock) begin
      rdy_cycle <= rdy_cycle + 1;
      if (rdy_cycle % 97 == 0) rdy_mode <= $urandom_range(2);
      case (rdy_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= $urandom_range(1);
         default: rsp_bus.ready <= ($urandom_range(3) == 0);
      endcase
   end

   // Predict on each request beat, check each response beat
   always @(posedge clock) begin
      request_t r;
      answer_t  got, want;
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         r.op = op_type'(req_bus.op);
         r.count = req_bus.item_count;
         r.each = req_bus.item_bytes;
         r.has = req_bus.has_address;
         r.addr = req_bus.payload_offset;
         want = serve_request(r);
         if (want.granted) granted_q.push_back(want.offset);
         answer_q.push_back(want);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.granted = rsp_bus.granted;
         got.offset = rsp_bus.result_offset;
         if (answer_q.size() == 0) begin
            $error("response beat with nothing expected: granted %0d offset %0d",
                   got.granted, got.offset);
            failures++;
         end else begin
            want = answer_q.pop_front();
            if (got.granted !== want.granted) begin
               $error("granted: expected %0d, actual %0d", want.granted, got.granted);
               failures++;
            end
            if (got.offset !== want.offset) begin
               $error("result_offset: expected %0d, actual %0d", want.offset, got.offset);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("tb_first_fit_arena_allocator failed");
         $finish;
      end
   end

   task automatic drain_requests();
      while (pending_q.size() > 0 || req_bus.valid) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      int          k, sent;
      logic [31:0] cnt, each;
      op_type      op;
      put_header(0, POOL - HSPAN, 1'b1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero size, tiny, rounding, oversize, whole pool, odd ops
      push_request(OP_ALLOC, 32'd0, 32'd5, 1'b0, 16'd0);
      push_request(OP_ALLOC, 32'd1, 32'd1, 1'b0, 16'd0);
      push_request(OP_ALLOC, 32'd17, 32'd1, 1'b0, 16'd0);
      push_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0);
      push_request(OP_ALLOC, 32'd65536, 32'd1, 1'b0, 16'd0);
      push_request(OP_ALLOC, 32'd65537, 32'd1, 1'b0, 16'd0);
      push_request(OP_ALLOC, 32'd2, 32'd3, 1'b0, 16'd0);
      push_request(OP_FREE, 32'd0, 32'd0, 1'b0, 16'd16);
      push_request(OP_FREE, 32'd0, 32'd0, 1'b1, 16'd0);
      push_request(OP_FREE, 32'd0, 32'd0, 1'b1, 16'd15);
      push_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      push_request(OP_REALLOC, 32'd4, 32'd1, 1'b0, 16'd0);
      push_request(OP_REALLOC, 32'd4, 32'd1, 1'b1, 16'd3);
      push_request(OP_REALLOC, 32'd0, 32'd9, 1'b1, 16'd48);
      push_request(OP_REALLOC, 32'd8, 32'd1, 1'b1, 16'd80);
      push_request(OP_REALLOC, 32'd100, 32'd1, 1'b1, 16'd16);
      push_request(OP_REALLOC, 32'd10, 32'd1, 1'b1, 16'd48);
      push_request(OP_REALLOC, 32'hFFFF_FFFF, 32'd2, 1'b1, 16'd48);
      push_request(OP_REALLOC, 32'd65536, 32'd1, 1'b1, 16'd80);
      push_request(OP_FREE, 32'd0, 32'd0, 1'b1, 16'd87);
      push_request(OP_ALLOC, 32'd65504, 32'd1, 1'b0, 16'd0);
      drain_requests();

      // Random: batches built from the current shadow arena
      sent = 0;
      while (sent < N_RANDOM) begin
         for (int i = 0; i < 16; i++) begin
            k = $urandom_range(99);
            op = (k < 45) ? OP_ALLOC : (k < 75) ? OP_FREE : (k < 96) ? OP_REALLOC : OP_NONE;
            pick_size(cnt, each);
            // Free and reallocate mostly name an address from pick_address, sometimes none
            if (op == OP_ALLOC || op == OP_NONE)
               push_request(op, cnt, each, $urandom_range(1), $urandom);
            else if ($urandom_range(19) == 0)
               push_request(op, cnt, each, 1'b0, $urandom);
            else
               push_request(op, cnt, each, 1'b1, pick_address());
            sent++;
         end
         drain_requests();
      end

      while (answer_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("tb_first_fit_arena_allocator passed");
      else
         $display("tb_first_fit_arena_allocator failed");
      $finish;
   end

endmodule

`default_nettype wire
